// File: hw/rtl/c2s_pkg.sv
// Shared types, constants and the arctangent table of the Cartesian-to-spherical converter.
package c2s_pkg;

    // Stage count of each CORDIC pass and the coordinate width.
    localparam int CORDIC_STAGES = 16;
    localparam int COORD_WIDTH   = 16;
    localparam int MAX_STAGES    = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    // Coordinates carry 16 guard bits plus headroom for the CORDIC gain;
    // at least 34 bits so the gain multiply splits at bit 32.
    localparam int GUARD_BITS = 16;
    localparam int DAT_W      = (COORD_WIDTH + 20 > 34) ? COORD_WIDTH + 20 : 34;
    localparam int GHI_W      = DAT_W - 32;

    // Angles with pi = 2^31.
    localparam int ANG_W      = 34;
    localparam int OUT_W      = 16;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DAT_W-1:0]       t_dat;
    typedef logic        [DAT_W-1:0]       t_udat;
    typedef logic signed [ANG_W-1:0]       t_ang;

    localparam t_ang ANG_PI      = 34'sd2147483648;
    localparam t_ang ANG_HALF_PI = 34'sd1073741824;
    localparam t_ang ANG_RND     = 34'sd32768;

    // Gain compensation factor K in Q0.32.
    localparam logic [31:0] GAIN_K = 32'd2608131496;

    // round(atan(2^-i) / pi * 2^31)
    localparam t_ang ATAN_TAB [0:MAX_STAGES-1] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    // Per-item sideband that travels with the datapath.
    typedef struct packed {
        logic               valid;
        logic               zero;
        logic               xy_zero;
        t_coord             z;
        logic [OUT_W-1:0]   theta;
        logic [OUT_W-1:0]   polar;
    } t_ctl;

endpackage

// File: hw/rtl/c2s_cordic_pass.sv
// One vectoring CORDIC pass, one register stage per iteration.
module c2s_cordic_pass (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  c2s_pkg::t_ctl i_ctl,
    input  c2s_pkg::t_dat i_x,
    input  c2s_pkg::t_dat i_y,
    input  c2s_pkg::t_ang i_ang,
    output c2s_pkg::t_ctl o_ctl,
    output c2s_pkg::t_dat o_x,
    output c2s_pkg::t_dat o_y,
    output c2s_pkg::t_ang o_ang
);
    import c2s_pkg::*;

    t_ctl s_ctl [0:CORDIC_N-1];
    t_dat s_x   [0:CORDIC_N-1];
    t_dat s_y   [0:CORDIC_N-1];
    t_ang s_a   [0:CORDIC_N-1];

    t_dat n_x   [0:CORDIC_N-1];
    t_dat n_y   [0:CORDIC_N-1];
    t_ang n_a   [0:CORDIC_N-1];

    t_ctl r_ctl [0:CORDIC_N-1];
    t_dat r_x   [0:CORDIC_N-1];
    t_dat r_y   [0:CORDIC_N-1];
    t_ang r_a   [0:CORDIC_N-1];

    genvar i;
    generate
        for (i = 0; i < CORDIC_N; i++) begin : g_iter
            if (i == 0) begin : g_first
                assign s_ctl[i] = i_ctl;
                assign s_x[i]   = i_x;
                assign s_y[i]   = i_y;
                assign s_a[i]   = i_ang;
            end else begin : g_next
                assign s_ctl[i] = r_ctl[i-1];
                assign s_x[i]   = r_x[i-1];
                assign s_y[i]   = r_y[i-1];
                assign s_a[i]   = r_a[i-1];
            end

            // rotate toward the x axis; shifts are floor
            always_comb begin
                if (!s_y[i][DAT_W-1]) begin
                    n_x[i] = s_x[i] + (s_y[i] >>> i);
                    n_y[i] = s_y[i] - (s_x[i] >>> i);
                    n_a[i] = s_a[i] + ATAN_TAB[i];
                end else begin
                    n_x[i] = s_x[i] - (s_y[i] >>> i);
                    n_y[i] = s_y[i] + (s_x[i] >>> i);
                    n_a[i] = s_a[i] - ATAN_TAB[i];
                end
            end

            always_ff @(posedge i_clk) begin
                r_ctl[i] <= s_ctl[i];
                r_x[i]   <= n_x[i];
                r_y[i]   <= n_y[i];
                r_a[i]   <= n_a[i];
                if (!i_rst_n) begin
                    r_ctl[i].valid <= 1'b0;
                end
            end
        end
    endgenerate

    assign o_ctl = r_ctl[CORDIC_N-1];
    assign o_x   = r_x[CORDIC_N-1];
    assign o_y   = r_y[CORDIC_N-1];
    assign o_ang = r_a[CORDIC_N-1];

endmodule

// File: hw/rtl/c2s_gain.sv
// CORDIC gain compensation: floor(a * K / 2^32) over two register stages.
module c2s_gain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  c2s_pkg::t_ctl  i_ctl,
    input  c2s_pkg::t_udat i_val,
    output c2s_pkg::t_ctl  o_ctl,
    output c2s_pkg::t_udat o_val
);
    import c2s_pkg::*;

    t_ctl        r_ctl_a;
    logic [63:0] r_lo_p;
    t_udat       r_hi_p;
    t_ctl        r_ctl_b;
    t_udat       r_val;

    // partial products: low 32 bits and high bits of the operand
    always_ff @(posedge i_clk) begin
        r_ctl_a <= i_ctl;
        r_lo_p  <= 64'(i_val[31:0]) * 64'(GAIN_K);
        r_hi_p  <= DAT_W'(i_val[DAT_W-1:32]) * DAT_W'(GAIN_K);
        if (!i_rst_n) begin
            r_ctl_a.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl_b <= r_ctl_a;
        r_val   <= r_hi_p + DAT_W'(r_lo_p[63:32]);
        if (!i_rst_n) begin
            r_ctl_b.valid <= 1'b0;
        end
    end

    assign o_ctl = r_ctl_b;
    assign o_val = r_val;

endmodule

// File: hw/rtl/cartesian_to_spherical_top.sv
// Top level of the Cartesian-to-spherical converter: input stage, two CORDIC passes, output.
//
// Converts one 3-D point (x, y, z) into radius, azimuth atan2(y, x) and
// polar angle from the +z axis; angles are in units of pi/32768.
// Input: a transfer happens at the rising edge where start is high and busy
// is low. busy is always low: the converter is a free-running pipeline and
// takes a new point in every cycle.
// Output: each result sits on o_radius, o_azimuth, o_polar and o_zero_point
// for exactly one cycle with o_valid high; the receiver cannot stall it, and
// nothing downstream can hold the pipeline.
// Throughput: one point per cycle. The pipeline has one register stage per
// CORDIC iteration, two per gain multiply, one input, one pre-rotation and
// one output stage.
// Pass one vectors (x, y) into r_xy and the azimuth; pass two vectors
// (z, r_xy) into the radius and the polar angle.
// The origin gives radius 0, both angles 0 and o_zero_point high.
// Reset (synchronous, active low) clears every valid bit in the pipeline;
// items in flight are dropped and o_valid stays low until new input comes.
module cartesian_to_spherical_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  c2s_pkg::t_coord         i_coord_x,
    input  c2s_pkg::t_coord         i_coord_y,
    input  c2s_pkg::t_coord         i_coord_z,
    output logic                    o_valid,
    output logic [15:0]             o_radius,
    output logic signed [15:0]      o_azimuth,
    output logic [15:0]             o_polar,
    output logic                    o_zero_point
);
    import c2s_pkg::*;

    localparam int LATENCY = 2 * CORDIC_N + 7;

    // ---------------- input register ----------------
    logic   r_in_vld;
    t_coord r_in_x;
    t_coord r_in_y;
    t_coord r_in_z;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_in_x <= i_coord_x;
        r_in_y <= i_coord_y;
        r_in_z <= i_coord_z;
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    // ---------------- pass one pre-rotation ----------------
    // Scale by 2^16; for negative x turn the vector by pi.
    t_dat xs, ys, p1_x0, p1_y0;
    t_ang p1_a0;
    t_ctl p1_ctl0;

    always_comb begin
        xs = $signed({{(DAT_W-COORD_WIDTH-GUARD_BITS){r_in_x[COORD_WIDTH-1]}},
                      r_in_x, {GUARD_BITS{1'b0}}});
        ys = $signed({{(DAT_W-COORD_WIDTH-GUARD_BITS){r_in_y[COORD_WIDTH-1]}},
                      r_in_y, {GUARD_BITS{1'b0}}});
        if (r_in_x[COORD_WIDTH-1]) begin
            p1_x0 = -xs;
            p1_y0 = -ys;
            p1_a0 = r_in_y[COORD_WIDTH-1] ? -ANG_PI : ANG_PI;
        end else begin
            p1_x0 = xs;
            p1_y0 = ys;
            p1_a0 = '0;
        end
        p1_ctl0.valid   = r_in_vld;
        p1_ctl0.xy_zero = (r_in_x == '0) && (r_in_y == '0);
        p1_ctl0.zero    = p1_ctl0.xy_zero && (r_in_z == '0);
        p1_ctl0.z       = r_in_z;
        p1_ctl0.theta   = '0;
        p1_ctl0.polar   = '0;
    end

    t_ctl p1_ctl;
    t_dat p1_x, p1_y;
    t_ang p1_a;

    c2s_cordic_pass u_pass1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (p1_ctl0),
        .i_x     (p1_x0),
        .i_y     (p1_y0),
        .i_ang   (p1_a0),
        .o_ctl   (p1_ctl),
        .o_x     (p1_x),
        .o_y     (p1_y),
        .o_ang   (p1_a)
    );

    // azimuth: round-half-up of angle / 2^16, low 16 bits (+pi wraps)
    t_ang theta_sum;
    t_ctl g1_ctl_in;

    always_comb begin
        theta_sum  = p1_a + ANG_RND;
        g1_ctl_in  = p1_ctl;
        g1_ctl_in.theta = p1_ctl.xy_zero ? '0 : theta_sum[GUARD_BITS +: OUT_W];
    end

    t_ctl  g1_ctl;
    t_udat g1_val;

    c2s_gain u_gain1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (g1_ctl_in),
        .i_val   ($unsigned(p1_x)),
        .o_ctl   (g1_ctl),
        .o_val   (g1_val)
    );

    // ---------------- pass two pre-rotation (registered) ----------------
    // For negative z turn (z, r_xy) by -pi/2 and start at +pi/2.
    t_dat zs;
    t_ctl r_p2_ctl;
    t_dat r_p2_x;
    t_dat r_p2_y;
    t_ang r_p2_a;

    assign zs = $signed({{(DAT_W-COORD_WIDTH-GUARD_BITS){g1_ctl.z[COORD_WIDTH-1]}},
                         g1_ctl.z, {GUARD_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_p2_ctl <= g1_ctl;
        if (g1_ctl.z[COORD_WIDTH-1]) begin
            r_p2_x <= $signed(g1_val);
            r_p2_y <= -zs;
            r_p2_a <= ANG_HALF_PI;
        end else begin
            r_p2_x <= zs;
            r_p2_y <= $signed(g1_val);
            r_p2_a <= '0;
        end
        if (!i_rst_n) begin
            r_p2_ctl.valid <= 1'b0;
        end
    end

    t_ctl p2_ctl;
    t_dat p2_x, p2_y;
    t_ang p2_a;

    c2s_cordic_pass u_pass2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_p2_ctl),
        .i_x     (r_p2_x),
        .i_y     (r_p2_y),
        .i_ang   (r_p2_a),
        .o_ctl   (p2_ctl),
        .o_x     (p2_x),
        .o_y     (p2_y),
        .o_ang   (p2_a)
    );

    // polar: rounded, then clamped to 0..pi
    t_ang                    phi_sum;
    logic signed [ANG_W-17:0] phi_q;
    t_ctl                    g2_ctl_in;

    always_comb begin
        phi_sum   = p2_a + ANG_RND;
        phi_q     = phi_sum[ANG_W-1:GUARD_BITS];
        g2_ctl_in = p2_ctl;
        if (phi_q < 0) begin
            g2_ctl_in.polar = '0;
        end else if (phi_q > $signed((ANG_W-16)'(32768))) begin
            g2_ctl_in.polar = 16'h8000;
        end else begin
            g2_ctl_in.polar = phi_q[OUT_W-1:0];
        end
    end

    t_ctl  g2_ctl;
    t_udat g2_val;

    c2s_gain u_gain2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (g2_ctl_in),
        .i_val   ($unsigned(p2_x)),
        .o_ctl   (g2_ctl),
        .o_val   (g2_val)
    );

    // ---------------- output register ----------------
    // radius: round-half-up of rho / 2^16, saturated at 65535
    logic [DAT_W:0]   rho_sum;
    logic [OUT_W-1:0] rho_q;

    always_comb begin
        rho_sum = {1'b0, g2_val} + (DAT_W+1)'(32768);
        if (|rho_sum[DAT_W:GUARD_BITS+OUT_W]) begin
            rho_q = '1;
        end else begin
            rho_q = rho_sum[GUARD_BITS +: OUT_W];
        end
    end

    logic               r_out_vld;
    logic [15:0]        r_radius;
    logic signed [15:0] r_azimuth;
    logic [15:0]        r_polar;
    logic               r_zero;

    always_ff @(posedge i_clk) begin
        r_zero    <= g2_ctl.zero;
        r_radius  <= g2_ctl.zero ? '0 : rho_q;
        r_azimuth <= $signed(g2_ctl.theta);
        r_polar   <= g2_ctl.zero ? '0 : g2_ctl.polar;
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= g2_ctl.valid;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_radius     = r_radius;
    assign o_azimuth    = r_azimuth;
    assign o_polar      = r_polar;
    assign o_zero_point = r_zero;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("accepted point did not come out after the pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching input transfer");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_point |-> o_radius == 16'd0 && o_azimuth == 16'sd0
                                     && o_polar == 16'd0)
        else $error("origin result carries nonzero fields");

    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_polar <= 16'd32768)
        else $error("polar angle beyond pi");

    a_reset_flush: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule
